@@ sv/sovg_pkg.sv @@
// Shared types and constants of the shape outline vector generator.
// Holds the input and output transaction structs, the command table
// and the star scale factors. Depends on nothing.
package sovg_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned ColorBits   = 8;
  localparam int unsigned ShapeBits   = 4;
  localparam int unsigned MaxCmds     = 6;
  localparam int unsigned CmdIdxBits  = $clog2(MaxCmds);
  localparam int unsigned FactorBits  = 17;
  localparam int unsigned FracBits    = 16;

  localparam logic signed [FactorBits-1:0] StarXLowLeft  = -17'sd38521;
  localparam logic signed [FactorBits-1:0] StarXLowRight =  17'sd38521;
  localparam logic signed [FactorBits-1:0] StarXMidLeft  = -17'sd62328;
  localparam logic signed [FactorBits-1:0] StarXMidRight =  17'sd62328;
  localparam logic signed [FactorBits-1:0] StarYLow      = -17'sd53020;
  localparam logic signed [FactorBits-1:0] StarYMid      =  17'sd20251;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        radius_t;
  typedef logic signed [ColorBits-1:0] color_t;
  typedef logic [CmdIdxBits-1:0]       cmd_idx_t;

  typedef enum logic [1:0] {
    OpMove = 2'd0,
    OpLine = 2'd1,
    OpBox  = 2'd2
  } op_e;

  typedef enum logic [ShapeBits-1:0] {
    ShapeLine      = 4'd0,
    ShapeCross     = 4'd1,
    ShapeBox       = 4'd2,
    ShapeStar      = 4'd3,
    ShapeTriangle  = 4'd4,
    ShapeDiamond   = 4'd5,
    ShapeVee       = 4'd6,
    ShapePlus      = 4'd7,
    ShapeHourglass = 4'd8,
    ShapeRoundBox  = 4'd9
  } shape_e;

  typedef struct packed {
    coord_t                first_x;
    coord_t                first_y;
    coord_t                second_x;
    coord_t                second_y;
    logic [ShapeBits-1:0]  shape;
    color_t                pen_color;
  } in_item_t;

  typedef struct packed {
    op_e     op;
    coord_t  point_x;
    coord_t  point_y;
    radius_t corner_rx;
    radius_t corner_ry;
    color_t  draw_color;
    logic    last;
  } out_item_t;

  typedef struct packed {
    op_e    op;
    coord_t x;
    coord_t y;
  } cmd_t;

  typedef struct packed {
    cmd_t [MaxCmds-1:0] cmd;
    cmd_idx_t           last_idx;
    radius_t            corner_rx;
    radius_t            corner_ry;
    color_t             color;
  } cmd_table_t;

endpackage

@@ sv/shape_outline_vector_generator.sv @@
// Top level of the shape outline vector generator: the command planning
// pipeline followed by the command emitter and the output register.
// Depends on sovg_pkg and sovg_plan.

// Each accepted transaction is planned in a three stage pipeline and its
// commands then leave one per cycle through an output register while
// out_ready_i does not stall it; the first command passes the three pipeline
// registers, the table register and the output register. A shape has two to
// six commands (six for the star), and sustained throughput is set by the
// single command output port. Shape codes 10 to 15 are accepted and yield no
// command. New transactions are taken while earlier shapes are still being
// emitted, as long as the pipeline has room.
module shape_outline_vector_generator
  import sovg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       plan_valid, tbl_ready;
  cmd_table_t plan_tbl;
  cmd_table_t tbl_q;
  logic       tbl_v_q;
  cmd_idx_t   idx_q;
  out_item_t  out_q, out_d;
  logic       out_v_q;
  logic       out_free, emit, tbl_done;
  cmd_t       cur;

  sovg_plan u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .tbl_valid_o (plan_valid),
    .tbl_ready_i (tbl_ready),
    .tbl_o       (plan_tbl)
  );

  assign out_free  = !out_v_q || out_ready_i;
  assign emit      = tbl_v_q && out_free;
  assign tbl_done  = emit && (idx_q == tbl_q.last_idx);
  assign tbl_ready = !tbl_v_q || tbl_done;
  assign cur       = tbl_q.cmd[idx_q];

  always_comb begin
    out_d            = '0;
    out_d.op         = cur.op;
    out_d.point_x    = cur.x;
    out_d.point_y    = cur.y;
    out_d.draw_color = tbl_q.color;
    out_d.last       = (idx_q == tbl_q.last_idx);
    if (cur.op == OpBox) begin
      out_d.corner_rx = tbl_q.corner_rx;
      out_d.corner_ry = tbl_q.corner_ry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (plan_valid && tbl_ready) begin
        tbl_v_q <= 1'b1;
        idx_q   <= '0;
      end else if (tbl_done) begin
        tbl_v_q <= 1'b0;
        idx_q   <= '0;
      end else if (emit) begin
        idx_q   <= idx_q + cmd_idx_t'(1);
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_valid && tbl_ready) begin
      tbl_q <= plan_tbl;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_idx_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_v_q |-> idx_q <= tbl_q.last_idx)
    else $error("command index ran past the end of the table");

  a_first_is_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && idx_q == '0 |-> cur.op == OpMove)
    else $error("shape does not start with a move command");

  a_radius_only_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.op != OpBox |-> out_q.corner_rx == '0 && out_q.corner_ry == '0)
    else $error("corner radius on a command that is not a box");

  a_rest_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.last |-> tbl_v_q)
    else $error("shape table released before its last command");
`endif

endmodule

@@ sv/sovg_plan.sv @@
// Three stage pipeline that turns one input transaction into a table of
// drawing commands: midpoints and half extents, star products, then the table.
// Depends on sovg_pkg.
module sovg_plan
  import sovg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       tbl_valid_o,
  input  logic       tbl_ready_i,
  output cmd_table_t tbl_o
);

  localparam int unsigned ProdBits = CoordBits + FactorBits;

  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [CoordBits:0]  offset_t;

  typedef struct packed {
    coord_t               x1;
    coord_t               y1;
    coord_t               x2;
    coord_t               y2;
    coord_t               mx;
    coord_t               my;
    coord_t               rx;
    coord_t               ry;
    radius_t              abs_dx;
    radius_t              abs_dy;
    logic [ShapeBits-1:0] shape;
    color_t               color;
  } geom_t;

  typedef struct packed {
    geom_t g;
    prod_t p_x_low_left;
    prod_t p_x_low_right;
    prod_t p_x_mid_left;
    prod_t p_x_mid_right;
    prod_t p_y_low;
    prod_t p_y_mid;
  } star_t;

  function automatic coord_t add_sat(coord_t base, offset_t off);
    logic signed [CoordBits+1:0] sum;
    sum = (CoordBits+2)'(base) + (CoordBits+2)'(off);
    if (sum[CoordBits+1:CoordBits-1] == {3{sum[CoordBits+1]}}) begin
      return sum[CoordBits-1:0];
    end else if (sum[CoordBits+1]) begin
      return {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordBits-1){1'b1}}};
    end
  endfunction

  function automatic cmd_t mk(op_e op, coord_t x, coord_t y);
    cmd_t c;
    c.op = op;
    c.x  = x;
    c.y  = y;
    return c;
  endfunction

  logic     v1_q, v2_q, v3_q;
  logic     s2_ready, s3_ready;
  in_item_t s1_q;
  geom_t    s2_d, s2_q;
  star_t    s3_d, s3_q;

  assign s3_ready   = !v3_q || tbl_ready_i;
  assign s2_ready   = !v2_q || s3_ready;
  assign in_ready_o = !v1_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i && (in_item_i.shape <= ShapeRoundBox);
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
      if (s3_ready) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_item_i;
    end
    if (v1_q && s2_ready) begin
      s2_q <= s2_d;
    end
    if (v2_q && s3_ready) begin
      s3_q <= s3_d;
    end
  end

  always_comb begin
    logic signed [CoordBits:0] sum_x, sum_y, dif_x, dif_y, abs_x, abs_y;
    sum_x = (CoordBits+1)'(s1_q.first_x) + (CoordBits+1)'(s1_q.second_x);
    sum_y = (CoordBits+1)'(s1_q.first_y) + (CoordBits+1)'(s1_q.second_y);
    dif_x = (CoordBits+1)'(s1_q.second_x) - (CoordBits+1)'(s1_q.first_x);
    dif_y = (CoordBits+1)'(s1_q.second_y) - (CoordBits+1)'(s1_q.first_y);
    abs_x = dif_x[CoordBits] ? -dif_x : dif_x;
    abs_y = dif_y[CoordBits] ? -dif_y : dif_y;
    s2_d.x1     = s1_q.first_x;
    s2_d.y1     = s1_q.first_y;
    s2_d.x2     = s1_q.second_x;
    s2_d.y2     = s1_q.second_y;
    s2_d.mx     = sum_x[CoordBits:1];
    s2_d.my     = sum_y[CoordBits:1];
    s2_d.rx     = dif_x[CoordBits:1];
    s2_d.ry     = dif_y[CoordBits:1];
    s2_d.abs_dx = abs_x[CoordBits-1:0];
    s2_d.abs_dy = abs_y[CoordBits-1:0];
    s2_d.shape  = s1_q.shape;
    s2_d.color  = s1_q.pen_color;
  end

  always_comb begin
    s3_d.g             = s2_q;
    s3_d.p_x_low_left  = ProdBits'(s2_q.rx) * ProdBits'(StarXLowLeft);
    s3_d.p_x_low_right = ProdBits'(s2_q.rx) * ProdBits'(StarXLowRight);
    s3_d.p_x_mid_left  = ProdBits'(s2_q.rx) * ProdBits'(StarXMidLeft);
    s3_d.p_x_mid_right = ProdBits'(s2_q.rx) * ProdBits'(StarXMidRight);
    s3_d.p_y_low       = ProdBits'(s2_q.ry) * ProdBits'(StarYLow);
    s3_d.p_y_mid       = ProdBits'(s2_q.ry) * ProdBits'(StarYMid);
  end

  always_comb begin
    geom_t  g;
    coord_t top, low_y, mid_y, sx_ll, sx_mr, sx_ml, sx_lr;
    g     = s3_q.g;
    top   = add_sat(g.my, (CoordBits+1)'(g.ry));
    low_y = add_sat(g.my, s3_q.p_y_low[ProdBits-1:FracBits]);
    mid_y = add_sat(g.my, s3_q.p_y_mid[ProdBits-1:FracBits]);
    sx_ll = add_sat(g.mx, s3_q.p_x_low_left[ProdBits-1:FracBits]);
    sx_mr = add_sat(g.mx, s3_q.p_x_mid_right[ProdBits-1:FracBits]);
    sx_ml = add_sat(g.mx, s3_q.p_x_mid_left[ProdBits-1:FracBits]);
    sx_lr = add_sat(g.mx, s3_q.p_x_low_right[ProdBits-1:FracBits]);
    tbl_o = '0;
    tbl_o.color = g.color;
    unique case (shape_e'(g.shape))
      ShapeLine: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.x2, g.y2);
        tbl_o.last_idx  = cmd_idx_t'(1);
      end
      ShapeCross: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.x2, g.y2);
        tbl_o.cmd[2]    = mk(OpMove, g.x1, g.y2);
        tbl_o.cmd[3]    = mk(OpLine, g.x2, g.y1);
        tbl_o.last_idx  = cmd_idx_t'(3);
      end
      ShapeBox: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpBox, g.x2, g.y2);
        tbl_o.last_idx  = cmd_idx_t'(1);
      end
      ShapeStar: begin
        tbl_o.cmd[0]    = mk(OpMove, g.mx, top);
        tbl_o.cmd[1]    = mk(OpLine, sx_ll, low_y);
        tbl_o.cmd[2]    = mk(OpLine, sx_mr, mid_y);
        tbl_o.cmd[3]    = mk(OpLine, sx_ml, mid_y);
        tbl_o.cmd[4]    = mk(OpLine, sx_lr, low_y);
        tbl_o.cmd[5]    = mk(OpLine, g.mx, top);
        tbl_o.last_idx  = cmd_idx_t'(5);
      end
      ShapeTriangle: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y2);
        tbl_o.cmd[1]    = mk(OpLine, g.mx, g.y1);
        tbl_o.cmd[2]    = mk(OpLine, g.x2, g.y2);
        tbl_o.cmd[3]    = mk(OpLine, g.x1, g.y2);
        tbl_o.last_idx  = cmd_idx_t'(3);
      end
      ShapeDiamond: begin
        tbl_o.cmd[0]    = mk(OpMove, g.mx, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.x1, g.my);
        tbl_o.cmd[2]    = mk(OpLine, g.mx, g.y2);
        tbl_o.cmd[3]    = mk(OpLine, g.x2, g.my);
        tbl_o.cmd[4]    = mk(OpLine, g.mx, g.y1);
        tbl_o.last_idx  = cmd_idx_t'(4);
      end
      ShapeVee: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.mx, g.y2);
        tbl_o.cmd[2]    = mk(OpLine, g.x2, g.y1);
        tbl_o.last_idx  = cmd_idx_t'(2);
      end
      ShapePlus: begin
        tbl_o.cmd[0]    = mk(OpMove, g.mx, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.mx, g.y2);
        tbl_o.cmd[2]    = mk(OpMove, g.x1, g.my);
        tbl_o.cmd[3]    = mk(OpLine, g.x2, g.my);
        tbl_o.last_idx  = cmd_idx_t'(3);
      end
      ShapeHourglass: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpLine, g.x2, g.y2);
        tbl_o.cmd[2]    = mk(OpLine, g.x1, g.y2);
        tbl_o.cmd[3]    = mk(OpLine, g.x2, g.y1);
        tbl_o.cmd[4]    = mk(OpLine, g.x1, g.y1);
        tbl_o.last_idx  = cmd_idx_t'(4);
      end
      ShapeRoundBox: begin
        tbl_o.cmd[0]    = mk(OpMove, g.x1, g.y1);
        tbl_o.cmd[1]    = mk(OpBox, g.x2, g.y2);
        tbl_o.last_idx  = cmd_idx_t'(1);
        tbl_o.corner_rx = g.abs_dx;
        tbl_o.corner_ry = g.abs_dy;
      end
      default: begin
        tbl_o.last_idx  = '0;
      end
    endcase
  end

  assign tbl_valid_o = v3_q;

endmodule
